FILE: src/swmm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swmm_pkg: shared types and constants
// Widths, register map and the entry and control records that flow between
// the deque cells of the sliding-window min/max block.
// ----------------------------------------------------------------------------
package swmm_pkg;

  localparam int SampleBits = 32;
  localparam int WindowMax  = 64;
  // Wide enough to hold WindowMax itself and to take ages modulo 2^IdxBits.
  localparam int IdxBits    = $clog2(WindowMax) + 1;
  localparam int LenBits    = 7;
  localparam int AddrBits   = 2;
  localparam int DataBits   = 32;

  localparam logic [AddrBits-1:0] RegWindowLen = AddrBits'(0);

  typedef struct packed {
    logic                         vld;
    logic signed [SampleBits-1:0] val;
    logic [IdxBits-1:0]           idx;
  } entry_t;

  typedef struct packed {
    logic                         step;
    logic                         shift;
    logic                         insert;
    logic                         rising;
    logic signed [SampleBits-1:0] sample;
    logic [IdxBits-1:0]           now;
    logic [IdxBits-1:0]           len;
  } cell_ctrl_t;

endpackage : swmm_pkg
`default_nettype wire

FILE: src/swmm_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swmm_cell: one deque position
// Holds one (value, index) entry, takes its right neighbor's entry on a shift,
// drops itself when the new sample dominates it, and loads the new sample when
// it is the first free position.
// ----------------------------------------------------------------------------
module swmm_cell (
  input  wire                                    clk_i,
  input  wire                                    rst_ni,
  input  swmm_pkg::cell_ctrl_t                   ctrl_i,
  input  swmm_pkg::entry_t                       right_i,
  input  wire                                    left_keep_i,
  output swmm_pkg::entry_t                       own_o,
  output logic                                   keep_o,
  output logic signed [swmm_pkg::SampleBits-1:0] nxt_val_o,
  output logic                                   expired_o
);

  logic                                   vld_q, vld_d;
  logic signed [swmm_pkg::SampleBits-1:0] val_q, val_d;
  logic [swmm_pkg::IdxBits-1:0]           idx_q, idx_d;
  swmm_pkg::entry_t                       src;
  logic                                   dom;
  logic                                   load;
  logic [swmm_pkg::IdxBits-1:0]           age;

  always_comb begin
    own_o.vld = vld_q;
    own_o.val = val_q;
    own_o.idx = idx_q;
    src       = ctrl_i.shift ? right_i : own_o;
    dom       = ctrl_i.rising ? (ctrl_i.sample <= src.val) : (ctrl_i.sample >= src.val);
    keep_o    = src.vld && !(ctrl_i.insert && dom);
    load      = ctrl_i.insert && !keep_o && left_keep_i;
    if (ctrl_i.step) begin
      vld_d = keep_o || load;
      val_d = load ? ctrl_i.sample : src.val;
      idx_d = load ? ctrl_i.now : src.idx;
    end else begin
      vld_d = vld_q;
      val_d = val_q;
      idx_d = idx_q;
    end
    nxt_val_o = val_d;
    age       = ctrl_i.now - idx_q;
    expired_o = vld_q && (age >= ctrl_i.len);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    idx_q <= idx_d;
  end

endmodule : swmm_cell
`default_nettype wire

FILE: src/swmm_deque.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swmm_deque: monotonic deque as a row of cells
// Front at cell 0. Each cycle of a sample either drops one expired front entry,
// or drops it (if any) and inserts the new sample in the same cycle.
// ----------------------------------------------------------------------------
module swmm_deque (
  input  wire                                    clk_i,
  input  wire                                    rst_ni,
  input  wire                                    act_i,
  input  wire                                    clr_i,
  input  wire                                    rising_i,
  input  wire signed [swmm_pkg::SampleBits-1:0]  sample_i,
  input  wire        [swmm_pkg::IdxBits-1:0]     now_i,
  input  wire        [swmm_pkg::IdxBits-1:0]     len_i,
  output logic                                   ins_o,
  output logic                                   done_o,
  output logic signed [swmm_pkg::SampleBits-1:0] front_o
);

  localparam int N = swmm_pkg::WindowMax;

  swmm_pkg::entry_t                       ent     [N];
  logic                                   keep    [N];
  logic signed [swmm_pkg::SampleBits-1:0] nval    [N];
  logic                                   expired [N];
  swmm_pkg::cell_ctrl_t                   ctrl;
  logic                                   exp_next;
  logic                                   done_q, done_d;

  generate
    if (N > 1) begin : g_next
      assign exp_next = expired[1];
    end else begin : g_single
      assign exp_next = 1'b0;
    end
  endgenerate

  always_comb begin
    ctrl.step   = act_i && !done_q;
    ctrl.shift  = expired[0];
    // Insert unless the new front is stale too; then only shift this cycle.
    ctrl.insert = !(expired[0] && exp_next);
    ctrl.rising = rising_i;
    ctrl.sample = sample_i;
    ctrl.now    = now_i;
    ctrl.len    = len_i;
    ins_o       = ctrl.step && ctrl.insert;
    done_d      = clr_i ? 1'b0 : (done_q || ins_o);
    done_o      = done_q;
    front_o     = nval[0];
  end

  generate
    for (genvar i = 0; i < N; i++) begin : g_cell
      swmm_pkg::entry_t right;
      logic             left_keep;
      if (i == N - 1) begin : g_last
        assign right = '0;
      end else begin : g_mid
        assign right = ent[i+1];
      end
      if (i == 0) begin : g_first
        assign left_keep = 1'b1;
      end else begin : g_rest
        assign left_keep = keep[i-1];
      end
      swmm_cell u_cell (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .ctrl_i     (ctrl),
        .right_i    (right),
        .left_keep_i(left_keep),
        .own_o      (ent[i]),
        .keep_o     (keep[i]),
        .nxt_val_o  (nval[i]),
        .expired_o  (expired[i])
      );
    end
  endgenerate

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= done_d;
    end
  end

endmodule : swmm_deque
`default_nettype wire

FILE: src/sliding_window_min_max_top.sv
`timescale 1ns / 1ps
`default_nettype none
// A result is registered at the edge that finishes its sample; when no extra entry
// expires that is the accepting edge itself, so valid rises in the next cycle.
// No sample is taken while one is in work or a result waits under result_stall_i; a
// sample stays in work longer when more than one entry expires at once in the busier
// deque (only after window_len is lowered): the cell rows drop one front entry per step.
// Reset: both deques empty, sample count zero, window_len = 1, no result pending.
// ----------------------------------------------------------------------------
// sliding_window_min_max_top: sliding-window minimum and maximum
// Two monotonic deques built as rows of cells, a rising one whose front is the
// window minimum and a falling one whose front is the window maximum.
// ----------------------------------------------------------------------------
module sliding_window_min_max_top (
  input  wire                                    clk_i,
  input  wire                                    rst_ni,
  // sample channel
  input  wire                                    sample_valid_i,
  output logic                                   sample_stall_o,
  input  wire signed [swmm_pkg::SampleBits-1:0]  sample_i,
  // result channel
  output logic                                   result_valid_o,
  input  wire                                    result_stall_i,
  output logic signed [swmm_pkg::SampleBits-1:0] window_min_o,
  output logic signed [swmm_pkg::SampleBits-1:0] window_max_o,
  // configuration port
  input  wire                                    psel,
  input  wire                                    penable,
  input  wire                                    pwrite,
  input  wire        [swmm_pkg::AddrBits-1:0]    paddr,
  input  wire        [swmm_pkg::DataBits-1:0]    pwdata,
  output logic       [swmm_pkg::DataBits-1:0]    prdata,
  output logic                                   pready
);

  localparam int IB = swmm_pkg::IdxBits;

  logic [swmm_pkg::LenBits-1:0]           win_len_q, win_len_d;
  logic                                   busy_q, busy_d;
  logic signed [swmm_pkg::SampleBits-1:0] smp_q;
  logic [IB-1:0]                          now_q, now_d;
  logic [IB-1:0]                          cnt_q, cnt_d;
  logic                                   filled_q, filled_d;
  logic                                   res_vld_q, res_vld_d;
  logic signed [swmm_pkg::SampleBits-1:0] res_min_q, res_max_q;

  logic                                   accept;
  logic                                   act;
  logic                                   fin;
  logic signed [swmm_pkg::SampleBits-1:0] cur;
  logic [IB-1:0]                          len;
  logic                                   lo_ins, lo_done, hi_ins, hi_done;
  logic signed [swmm_pkg::SampleBits-1:0] lo_front, hi_front;
  logic                                   cfg_wr;

  // Configuration: a single register; pready is tied high.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    win_len_d = win_len_q;
    if (cfg_wr && paddr == swmm_pkg::RegWindowLen) begin
      win_len_d = pwdata[swmm_pkg::LenBits-1:0];
    end
    prdata = '0;
    if (paddr == swmm_pkg::RegWindowLen) begin
      prdata = swmm_pkg::DataBits'(win_len_q);
    end
  end

  // Clamp the window length: zero acts as one, above the row length saturates.
  always_comb begin
    if (win_len_q == '0) begin
      len = IB'(1);
    end else if (32'(win_len_q) > swmm_pkg::WindowMax) begin
      len = IB'(swmm_pkg::WindowMax);
    end else begin
      len = IB'(win_len_q);
    end
  end

  // Hold off new samples while one is still in work or a result waits.
  assign sample_stall_o = busy_q || (res_vld_q && result_stall_i);
  assign accept         = sample_valid_i && !sample_stall_o;
  assign act            = accept || busy_q;
  assign cur            = busy_q ? smp_q : sample_i;
  // The sample is finished once both deques have placed it.
  assign fin            = act && (lo_done || lo_ins) && (hi_done || hi_ins);

  swmm_deque u_lo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .act_i   (act),
    .clr_i   (fin),
    .rising_i(1'b1),
    .sample_i(cur),
    .now_i   (now_q),
    .len_i   (len),
    .ins_o   (lo_ins),
    .done_o  (lo_done),
    .front_o (lo_front)
  );

  swmm_deque u_hi (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .act_i   (act),
    .clr_i   (fin),
    .rising_i(1'b0),
    .sample_i(cur),
    .now_i   (now_q),
    .len_i   (len),
    .ins_o   (hi_ins),
    .done_o  (hi_done),
    .front_o (hi_front)
  );

  always_comb begin
    busy_d   = act && !fin;
    now_d    = now_q;
    cnt_d    = cnt_q;
    filled_d = filled_q;
    if (fin) begin
      // Advance the sample index; ages are taken modulo 2^IdxBits.
      now_d    = now_q + IB'(1);
      cnt_d    = (32'(cnt_q) >= swmm_pkg::WindowMax) ? cnt_q : cnt_q + IB'(1);
      filled_d = filled_q || (cnt_q >= len - IB'(1));
    end
    // Drop a taken result; load a new one when a filled window completes.
    if (fin && filled_d) begin
      res_vld_d = 1'b1;
    end else begin
      res_vld_d = res_vld_q && result_stall_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_len_q <= swmm_pkg::LenBits'(1);
      busy_q    <= 1'b0;
      now_q     <= '0;
      cnt_q     <= '0;
      filled_q  <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      win_len_q <= win_len_d;
      busy_q    <= busy_d;
      now_q     <= now_d;
      cnt_q     <= cnt_d;
      filled_q  <= filled_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      smp_q <= sample_i;
    end
    if (fin && filled_d) begin
      res_min_q <= lo_front;
      res_max_q <= hi_front;
    end
  end

  assign result_valid_o = res_vld_q;
  assign window_min_o   = res_min_q;
  assign window_max_o   = res_max_q;

endmodule : sliding_window_min_max_top
`default_nettype wire
